### hdl/bmvg_pkg.sv
// ----------------------------------------------------------------------------
// bmvg_pkg
// Shared types, constants and the face table for the box mesh vertex
// generator.
// ----------------------------------------------------------------------------
package bmvg_pkg;

  // Largest segment count that is honored; larger counts are clamped.
  localparam int SEG_MAX = 64;

  // Field widths.
  localparam int SEG_W   = 7;
  localparam int SIZE_W  = 16;
  localparam int FACE_W  = 3;
  localparam int POS_W   = 17;
  localparam int TEX_W   = 17;
  localparam int IDX_W   = 15;

  // Reciprocal divider: dividends stay below 2**NUM_W, divisors below 2**SEG_W.
  localparam int NUM_W   = 24;
  localparam int DIV_K   = 31;
  localparam int RECIP_W = 32;

  // Number of faces and configuration register indexes.
  localparam int NUM_FACES = 6;

  typedef enum logic [2:0] {
    REG_BOX_WIDTH   = 3'd0,
    REG_BOX_HEIGHT  = 3'd1,
    REG_BOX_DEPTH   = 3'd2,
    REG_SEGS_ACROSS = 3'd3,
    REG_SEGS_UP     = 3'd4,
    REG_SEGS_DEEP   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Axis assignment and direction of one face.
  typedef struct packed {
    axis_t u_axis;
    axis_t v_axis;
    axis_t w_axis;
    logic  u_neg;
    logic  v_neg;
    logic  w_neg;
  } face_desc_t;

  // Face table; face numbers six and seven return an all-zero entry.
  function automatic face_desc_t face_lookup(logic [FACE_W-1:0] f);
    face_desc_t d;
    d = '{u_axis: AXIS_X, v_axis: AXIS_X, w_axis: AXIS_X,
          u_neg: 1'b0, v_neg: 1'b0, w_neg: 1'b0};
    case (f)
      3'd0: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1, 1'b0};
      3'd1: d = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1, 1'b1};
      3'd2: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0, 1'b0};
      3'd3: d = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1, 1'b1};
      3'd4: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0};
      3'd5: d = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1, 1'b1};
      default: d = '{AXIS_X, AXIS_X, AXIS_X, 1'b0, 1'b0, 1'b0};
    endcase
    return d;
  endfunction

  // A count of zero is used as one, and a count above SEG_MAX as SEG_MAX.
  function automatic logic [SEG_W-1:0] seg_clamp(logic [SEG_W-1:0] s);
    logic [SEG_W-1:0] r;
    r = s;
    if (r == '0) begin
      r = SEG_W'(1);
    end
    if (32'(r) > SEG_MAX) begin
      r = SEG_W'(SEG_MAX);
    end
    return r;
  endfunction

endpackage

### hdl/box_mesh_vertex_generator_unit.sv
// ----------------------------------------------------------------------------
// box_mesh_vertex_generator_unit
// Returns position, texture coordinate, normal and mesh indexes of one grid
// point on one face of a segmented box, one point per cycle unless stalled.
// ----------------------------------------------------------------------------
// Three register stages; an accepted point moves through stages 1, 2 and 3,
// and out_valid is the valid bit of stage 3. Throughput: one point per cycle
// while out_stall is low. Each stage holds a valid bit and advances when the
// next stage has room. Reset (rst, synchronous) empties the pipeline and
// loads the box sizes with 256 and the segment counts with 1.
module box_mesh_vertex_generator_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration port.
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [bmvg_pkg::SIZE_W-1:0]     cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bmvg_pkg::FACE_W-1:0]     face,
  input  logic [bmvg_pkg::SEG_W-1:0]      grid_row,
  input  logic [bmvg_pkg::SEG_W-1:0]      grid_col,
  // Output channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [bmvg_pkg::POS_W-1:0] pos_x,
  output logic signed [bmvg_pkg::POS_W-1:0] pos_y,
  output logic signed [bmvg_pkg::POS_W-1:0] pos_z,
  output logic [bmvg_pkg::TEX_W-1:0]      tex_u,
  output logic [bmvg_pkg::TEX_W-1:0]      tex_v,
  output logic [1:0]                      normal_axis,
  output logic                            normal_negative,
  output logic [bmvg_pkg::IDX_W-1:0]      vertex_index,
  output logic [bmvg_pkg::IDX_W-1:0]      upper_index,
  output logic                            quad_valid,
  output logic                            out_of_range
);

  localparam int SegW   = bmvg_pkg::SEG_W;
  localparam int SizeW  = bmvg_pkg::SIZE_W;
  localparam int NumW   = bmvg_pkg::NUM_W;
  localparam int RecW   = bmvg_pkg::RECIP_W;
  localparam int DivK   = bmvg_pkg::DIV_K;
  localparam int ProdW  = NumW + RecW;
  localparam int QuoW   = SizeW + 2;
  localparam int CntW   = 2 * (SegW + 1);
  localparam int SumW   = bmvg_pkg::IDX_W + 1;
  localparam int TabN   = 1 << SegW;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] box_width, box_height, box_depth;
  logic [SegW-1:0]  segs_across, segs_up, segs_deep;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width   <= SizeW'(256);
      box_height  <= SizeW'(256);
      box_depth   <= SizeW'(256);
      segs_across <= SegW'(1);
      segs_up     <= SegW'(1);
      segs_deep   <= SegW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bmvg_pkg::REG_BOX_WIDTH:   box_width   <= cfg_data;
        bmvg_pkg::REG_BOX_HEIGHT:  box_height  <= cfg_data;
        bmvg_pkg::REG_BOX_DEPTH:   box_depth   <= cfg_data;
        bmvg_pkg::REG_SEGS_ACROSS: segs_across <= cfg_data[SegW-1:0];
        bmvg_pkg::REG_SEGS_UP:     segs_up     <= cfg_data[SegW-1:0];
        bmvg_pkg::REG_SEGS_DEEP:   segs_deep   <= cfg_data[SegW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Reciprocal table: ceil(2**DivK / d), so that floor(n / d) is the top part
  // of n times the entry for every dividend in range.
  // --------------------------------------------------------------------------
  logic [RecW-1:0] recip_tab [TabN];

  assign recip_tab[0] = '0;
  for (genvar d = 1; d < TabN; d++) begin : g_recip
    localparam logic [RecW-1:0] Recip = RecW'(((64'd1 << DivK) + d - 1) / d);
    assign recip_tab[d] = Recip;
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage moves when it is empty or the next one moves.
  // --------------------------------------------------------------------------
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3      = !v3 || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: face decode, operand selection, dividends and face counts.
  // --------------------------------------------------------------------------
  bmvg_pkg::face_desc_t desc_c, desc1;
  logic [SegW-1:0]  sx_c, sy_c, sz_c, seg_u_c, seg_v_c;
  logic [SizeW-1:0] size_u_c, size_v_c, size_w_c;
  logic             oor_c;

  logic [2:0]       face1;
  logic [SegW-1:0]  seg_u1, seg_v1, row1, col1;
  logic [SizeW-1:0] size_u1, size_v1, size_w1;
  logic             oor1;
  logic [NumW-1:0]  num_u1, num_v1, tnum_u1, tnum_v1;
  logic [RecW-1:0]  rec_u1, rec_v1;
  logic [CntW-1:0]  row_off1, cxy1, cxz1, czy1;

  always_comb begin
    sx_c   = bmvg_pkg::seg_clamp(segs_across);
    sy_c   = bmvg_pkg::seg_clamp(segs_up);
    sz_c   = bmvg_pkg::seg_clamp(segs_deep);
    desc_c = bmvg_pkg::face_lookup(face);
    seg_u_c  = sx_c;
    size_u_c = box_width;
    case (desc_c.u_axis)
      bmvg_pkg::AXIS_Y: begin seg_u_c = sy_c; size_u_c = box_height; end
      bmvg_pkg::AXIS_Z: begin seg_u_c = sz_c; size_u_c = box_depth;  end
      default:          begin seg_u_c = sx_c; size_u_c = box_width;  end
    endcase
    case (desc_c.v_axis)
      bmvg_pkg::AXIS_Y: begin seg_v_c = sy_c; size_v_c = box_height; end
      bmvg_pkg::AXIS_Z: begin seg_v_c = sz_c; size_v_c = box_depth;  end
      default:          begin seg_v_c = sx_c; size_v_c = box_width;  end
    endcase
    case (desc_c.w_axis)
      bmvg_pkg::AXIS_Y: size_w_c = box_height;
      bmvg_pkg::AXIS_Z: size_w_c = box_depth;
      default:          size_w_c = box_width;
    endcase
    oor_c = (32'(face) >= bmvg_pkg::NUM_FACES) || (grid_row > seg_v_c) ||
            (grid_col > seg_u_c);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      face1    <= face;
      desc1    <= desc_c;
      seg_u1   <= seg_u_c;
      seg_v1   <= seg_v_c;
      size_u1  <= size_u_c;
      size_v1  <= size_v_c;
      size_w1  <= size_w_c;
      row1     <= grid_row;
      col1     <= grid_col;
      oor1     <= oor_c;
      num_u1   <= NumW'({grid_col, 1'b0}) * NumW'(size_u_c);
      num_v1   <= NumW'({grid_row, 1'b0}) * NumW'(size_v_c);
      tnum_u1  <= NumW'({grid_col, 16'b0});
      tnum_v1  <= NumW'({grid_row, 16'b0});
      rec_u1   <= recip_tab[seg_u_c];
      rec_v1   <= recip_tab[seg_v_c];
      row_off1 <= CntW'(grid_row) * CntW'({1'b0, seg_u_c} + 1'b1);
      cxy1     <= CntW'({1'b0, sx_c} + 1'b1) * CntW'({1'b0, sy_c} + 1'b1);
      cxz1     <= CntW'({1'b0, sx_c} + 1'b1) * CntW'({1'b0, sz_c} + 1'b1);
      czy1     <= CntW'({1'b0, sz_c} + 1'b1) * CntW'({1'b0, sy_c} + 1'b1);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: reciprocal multiplies and the face base index.
  // --------------------------------------------------------------------------
  bmvg_pkg::face_desc_t desc2;
  logic [SegW-1:0]  seg_u2, seg_v2, row2, col2;
  logic [SizeW-1:0] size_u2, size_v2, size_w2;
  logic             oor2;
  logic [ProdW-1:0] prod_u2, prod_v2, prod_tu2, prod_tv2;
  logic [SumW-1:0]  base_c, base2;
  logic [CntW-1:0]  row_off2;

  always_comb begin
    case (face1)
      3'd1:    base_c = SumW'(cxy1);
      3'd2:    base_c = SumW'({cxy1, 1'b0});
      3'd3:    base_c = SumW'({cxy1, 1'b0}) + SumW'(cxz1);
      3'd4:    base_c = SumW'({cxy1, 1'b0}) + SumW'({cxz1, 1'b0});
      3'd5:    base_c = SumW'({cxy1, 1'b0}) + SumW'({cxz1, 1'b0}) + SumW'(czy1);
      default: base_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      desc2    <= desc1;
      seg_u2   <= seg_u1;
      seg_v2   <= seg_v1;
      row2     <= row1;
      col2     <= col1;
      size_u2  <= size_u1;
      size_v2  <= size_v1;
      size_w2  <= size_w1;
      oor2     <= oor1;
      prod_u2  <= num_u1 * rec_u1;
      prod_v2  <= num_v1 * rec_v1;
      prod_tu2 <= tnum_u1 * rec_u1;
      prod_tv2 <= tnum_v1 * rec_v1;
      base2    <= base_c;
      row_off2 <= row_off1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quotients, signs, axis placement, indexes and output register.
  // --------------------------------------------------------------------------
  localparam int POS_W_LOCAL = bmvg_pkg::POS_W;
  logic signed [QuoW:0] cu_c, cv_c, cw_c;
  logic [QuoW-1:0]      qu_c, qv_c, qtu_c, qtv_c;
  logic [SumW-1:0]      vidx_c, upper_c;
  logic signed [POS_W_LOCAL-1:0] px_c, py_c, pz_c;

  always_comb begin
    qu_c  = prod_u2[DivK +: QuoW];
    qv_c  = prod_v2[DivK +: QuoW];
    qtu_c = prod_tu2[DivK +: QuoW];
    qtv_c = prod_tv2[DivK +: QuoW];
    cu_c  = $signed({1'b0, qu_c}) - $signed({3'b0, size_u2});
    cv_c  = $signed({1'b0, qv_c}) - $signed({3'b0, size_v2});
    cw_c  = $signed({3'b0, size_w2});
    if (desc2.u_neg) cu_c = -cu_c;
    if (desc2.v_neg) cv_c = -cv_c;
    if (desc2.w_neg) cw_c = -cw_c;
    // Place each coordinate on the axis that it belongs to.
    px_c = POS_W_LOCAL'(cw_c);
    py_c = POS_W_LOCAL'(cw_c);
    pz_c = POS_W_LOCAL'(cw_c);
    if (desc2.u_axis == bmvg_pkg::AXIS_X) px_c = POS_W_LOCAL'(cu_c);
    if (desc2.u_axis == bmvg_pkg::AXIS_Y) py_c = POS_W_LOCAL'(cu_c);
    if (desc2.u_axis == bmvg_pkg::AXIS_Z) pz_c = POS_W_LOCAL'(cu_c);
    if (desc2.v_axis == bmvg_pkg::AXIS_X) px_c = POS_W_LOCAL'(cv_c);
    if (desc2.v_axis == bmvg_pkg::AXIS_Y) py_c = POS_W_LOCAL'(cv_c);
    if (desc2.v_axis == bmvg_pkg::AXIS_Z) pz_c = POS_W_LOCAL'(cv_c);
    vidx_c  = base2 + SumW'(col2) + SumW'(row_off2);
    upper_c = vidx_c + SumW'(seg_u2) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      normal_axis     <= desc2.w_axis;
      normal_negative <= desc2.w_neg;
      out_of_range    <= oor2;
      if (oor2) begin
        pos_x        <= '0;
        pos_y        <= '0;
        pos_z        <= '0;
        tex_u        <= '0;
        tex_v        <= '0;
        vertex_index <= '0;
        upper_index  <= '0;
        quad_valid   <= 1'b0;
      end else begin
        pos_x        <= px_c;
        pos_y        <= py_c;
        pos_z        <= pz_c;
        tex_u        <= qtu_c[bmvg_pkg::TEX_W-1:0];
        tex_v        <= bmvg_pkg::TEX_W'(18'd65536 - qtv_c);
        vertex_index <= vidx_c[bmvg_pkg::IDX_W-1:0];
        upper_index  <= (row2 < seg_v2) ? upper_c[bmvg_pkg::IDX_W-1:0] : '0;
        quad_valid   <= (row2 < seg_v2) && (col2 < seg_u2);
      end
    end
  end

  assign out_valid = v3;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The input side stalls only while the first stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1)
    else $error("input stalled with an empty first stage");

  // A point outside its face carries no indexes and starts no quad.
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (vertex_index == '0 && upper_index == '0 && !quad_valid))
    else $error("out-of-range point carries index data");

  // A quad always has a vertex above it.
  a_quad_upper: assert property (@(posedge clk) disable iff (rst)
    (out_valid && quad_valid) |-> (upper_index != '0 && !out_of_range))
    else $error("quad without an upper vertex");

endmodule

### tb/box_mesh_vertex_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// box_mesh_vertex_generator_unit_tb
// Self-checking testbench for the box mesh vertex generator. A short table of
// directed grid points is applied first, followed by random points under
// several box configurations. Every output transfer is checked field by
// field against its typed or predicted vertex; both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_mesh_vertex_generator_unit_tb;

  localparam int POS_W   = bmvg_pkg::POS_W;
  localparam int TEX_W   = bmvg_pkg::TEX_W;
  localparam int IDX_W   = bmvg_pkg::IDX_W;
  localparam int FACE_W  = bmvg_pkg::FACE_W;
  localparam int SEG_W   = bmvg_pkg::SEG_W;
  localparam int SIZE_W  = bmvg_pkg::SIZE_W;
  localparam int SEG_MAX = bmvg_pkg::SEG_MAX;
  typedef bmvg_pkg::axis_t axis_t;

  // Register indexes that the block does not decode.
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DRAIN  = 12;
  localparam int NUM_PHASES  = 7;
  localparam int PHASE_ITEMS = 150;

  // One vertex as the block returns it.
  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [TEX_W-1:0]        tu;
    logic [TEX_W-1:0]        tv;
    logic [1:0]              n_axis;
    logic                    n_neg;
    logic [IDX_W-1:0]        v_idx;
    logic [IDX_W-1:0]        u_idx;
    logic                    quad;
    logic                    oor;
  } vertex_t;

  // Axis mapping of one face.
  typedef struct packed {
    axis_t ua;
    axis_t va;
    axis_t wa;
    logic  un;
    logic  vn;
    logic  wn;
  } face_map_t;

  // One directed grid point, with an optional hand-written expectation.
  typedef struct {
    logic [FACE_W-1:0] f;
    logic [SEG_W-1:0]  r;
    logic [SEG_W-1:0]  c;
    bit                typed;
    vertex_t           want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FACE_W-1:0] face = '0;
  logic [SEG_W-1:0] grid_row = '0;
  logic [SEG_W-1:0] grid_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic [1:0] normal_axis;
  logic normal_negative;
  logic [IDX_W-1:0] vertex_index, upper_index;
  logic quad_valid, out_of_range;

  box_mesh_vertex_generator_unit dut (.*);

  // Shadow copy of the configuration registers.
  int box_size [3];
  int box_segs [3];

  vertex_t pending_vertices [$];
  vertex_t cur_want;
  bit cur_typed = 1'b0;
  bit calm = 1'b0;
  int errors = 0;
  int cycles = 0;
  int out_wait = 0;
  bit out_took = 1'b0;
  point_row_t points [23];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic face_map_t face_map(int f);
    case (f)
      0: return '{bmvg_pkg::AXIS_X, bmvg_pkg::AXIS_Y, bmvg_pkg::AXIS_Z, 1'b0, 1'b1, 1'b0};
      1: return '{bmvg_pkg::AXIS_X, bmvg_pkg::AXIS_Y, bmvg_pkg::AXIS_Z, 1'b1, 1'b1, 1'b1};
      2: return '{bmvg_pkg::AXIS_X, bmvg_pkg::AXIS_Z, bmvg_pkg::AXIS_Y, 1'b0, 1'b0, 1'b0};
      3: return '{bmvg_pkg::AXIS_X, bmvg_pkg::AXIS_Z, bmvg_pkg::AXIS_Y, 1'b0, 1'b1, 1'b1};
      4: return '{bmvg_pkg::AXIS_Z, bmvg_pkg::AXIS_Y, bmvg_pkg::AXIS_X, 1'b1, 1'b1, 1'b0};
      default: return '{bmvg_pkg::AXIS_Z, bmvg_pkg::AXIS_Y, bmvg_pkg::AXIS_X,
                        1'b0, 1'b1, 1'b1};
    endcase
  endfunction

  // Segment count as the block uses it: zero acts as one, large counts clamp.
  function automatic int eff_segs(int axis);
    int s;
    s = box_segs[axis];
    if (s == 0) s = 1;
    if (s > SEG_MAX) s = SEG_MAX;
    return s;
  endfunction

  function automatic int grid_pos(int idx, int size, int seg, logic neg);
    int c;
    c = (2 * idx * size) / seg - size;
    return neg ? -c : c;
  endfunction

  // Vertex predictor for one grid point under the shadow configuration.
  function automatic vertex_t predict_vertex(int f, int r, int c);
    vertex_t v;
    face_map_t m;
    int su, sv, base, vi;
    int p [3];
    v = '0;
    if (f > 5) begin
      v.oor = 1'b1;
      return v;
    end
    m = face_map(f);
    su = eff_segs(m.ua);
    sv = eff_segs(m.va);
    v.n_axis = m.wa;
    v.n_neg = m.wn;
    if (r > sv || c > su) begin
      v.oor = 1'b1;
      return v;
    end
    p[m.ua] = grid_pos(c, box_size[m.ua], su, m.un);
    p[m.va] = grid_pos(r, box_size[m.va], sv, m.vn);
    p[m.wa] = m.wn ? -box_size[m.wa] : box_size[m.wa];
    v.px = POS_W'(p[0]);
    v.py = POS_W'(p[1]);
    v.pz = POS_W'(p[2]);
    v.tu = TEX_W'((c * 65536) / su);
    v.tv = TEX_W'(65536 - (r * 65536) / sv);
    base = 0;
    for (int k = 0; k < f; k++) begin
      base += (eff_segs(face_map(k).ua) + 1) * (eff_segs(face_map(k).va) + 1);
    end
    vi = base + c + r * (su + 1);
    v.v_idx = IDX_W'(vi);
    if (r < sv) v.u_idx = IDX_W'(vi + su + 1);
    v.quad = (r < sv) && (c < su);
    return v;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
    end
  endtask

  // Input and output transfers, shadow register writes and the timeout.
  always @(posedge clk) begin
    vertex_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && cfg_we) begin
      if (cfg_index < 3) box_size[cfg_index] = int'(cfg_data);
      else if (cfg_index < 6) box_segs[cfg_index - 3] = int'(cfg_data[SEG_W-1:0]);
    end
    if (!rst && in_valid && !in_stall) begin
      w = cur_typed ? cur_want : predict_vertex(face, grid_row, grid_col);
      pending_vertices = {pending_vertices, w};
    end
    if (!rst && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (pending_vertices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("output transfer with no vertex pending");
      end else begin
        w = pending_vertices.pop_front();
        check_field("pos_x", w.px, pos_x);
        check_field("pos_y", w.py, pos_y);
        check_field("pos_z", w.pz, pos_z);
        check_field("tex_u", w.tu, tex_u);
        check_field("tex_v", w.tv, tex_v);
        check_field("normal_axis", w.n_axis, normal_axis);
        check_field("normal_negative", w.n_neg, normal_negative);
        check_field("vertex_index", w.v_idx, vertex_index);
        check_field("upper_index", w.u_idx, upper_index);
        check_field("quad_valid", w.quad, quad_valid);
        check_field("out_of_range", w.oor, out_of_range);
      end
    end
  end

  // Output stall: a fresh random wait after each transfer, none when calm is set.
  always @(negedge clk) begin
    if (out_took) begin
      out_wait = calm ? 0 : $urandom_range(0, 3);
      out_took = 1'b0;
    end
    out_stall <= (out_wait != 0);
    if (out_wait != 0) out_wait--;
  end

  task automatic send_point(logic [FACE_W-1:0] f, logic [SEG_W-1:0] r,
                            logic [SEG_W-1:0] c, bit typed, vertex_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    face <= f;
    grid_row <= r;
    grid_col <= c;
    in_valid <= 1'b1;
    cur_typed = typed;
    cur_want = want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [SIZE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Waits until every pending vertex has come out and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_segs();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd64;
      3: return 16'd127;
      4: return SIZE_W'($urandom_range(65, 127));
      default: return SIZE_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int n;
    int f, sv, su;
    face_map_t m;
    logic [SIZE_W-1:0] sz [3];
    logic [SIZE_W-1:0] sg [3];
    for (int a = 0; a < 3; a++) begin
      box_size[a] = 256;
      box_segs[a] = 1;
    end

    // Hand-checked points under the reset configuration.
    points[0] = '{3'd0, 7'd0, 7'd0, 1'b1,
                  '{-256, 256, 256, 0, 65536, 2, 0, 0, 2, 1, 0}};
    points[1] = '{3'd6, 7'd0, 7'd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}};
    points[2] = '{3'd7, 7'd127, 7'd127, 1'b1,
                  '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1}};
    points[3] = '{3'd0, 7'd2, 7'd0, 1'b1, '{0, 0, 0, 0, 0, 2, 0, 0, 0, 0, 1}};
    points[4] = '{3'd5, 7'd0, 7'd127, 1'b1,
                  '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1}};
    // Three corners of every face, including the top row, left to the predictor.
    n = 5;
    for (int k = 0; k < 6; k++) begin
      points[n++] = '{3'(k), 7'd0, 7'd1, 1'b0, '0};
      points[n++] = '{3'(k), 7'd1, 7'd0, 1'b0, '0};
      points[n++] = '{3'(k), 7'd1, 7'd1, 1'b0, '0};
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (points[i]) begin
      send_point(points[i].f, points[i].r, points[i].c, points[i].typed,
                 points[i].want);
    end
    drain();

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      // New box: largest sizes first, then zero and out-of-range counts, then random.
      for (int a = 0; a < 3; a++) begin
        case (ph)
          1: begin
            sz[a] = 16'hFFFF;
            sg[a] = 16'd64;
          end
          2: begin
            sz[a] = (a == 1) ? 16'd0 : 16'd1;
            sg[a] = (a == 0) ? 16'd0 : 16'd127;
          end
          default: begin
            sz[a] = pick_size();
            sg[a] = pick_segs();
          end
        endcase
      end
      write_reg(bmvg_pkg::REG_BOX_WIDTH, sz[0]);
      write_reg(bmvg_pkg::REG_BOX_HEIGHT, sz[1]);
      write_reg(bmvg_pkg::REG_BOX_DEPTH, sz[2]);
      write_reg(bmvg_pkg::REG_SEGS_ACROSS, sg[0]);
      write_reg(bmvg_pkg::REG_SEGS_UP, sg[1]);
      write_reg(bmvg_pkg::REG_SEGS_DEEP, sg[2]);
      // Writes to undecoded indexes must leave the box unchanged.
      write_reg(REG_SPARE_LO, SIZE_W'($urandom));
      write_reg(REG_SPARE_HI, SIZE_W'($urandom));
      @(negedge clk);
      cfg_we <= 1'b0;
      calm = (ph % 3 == 0);

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) begin
          f = $urandom_range(0, 5);
          m = face_map(f);
          su = eff_segs(m.ua);
          sv = eff_segs(m.va);
          send_point(FACE_W'(f), SEG_W'($urandom_range(0, sv)),
                     SEG_W'($urandom_range(0, su)), 1'b0, '0);
        end else begin
          send_point(FACE_W'($urandom), SEG_W'($urandom), SEG_W'($urandom),
                     1'b0, '0);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
